// File: design/pfic_pkg.sv
// ----------------------------------------------------------------------------
// pfic_pkg: shared types and constants
// Word formats, configuration set and register map for the pump flow
// interlock controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pfic_pkg;

	// window end needs at least this many pulses for a nonzero rate
	localparam int unsigned MIN_PULSES = 2;

	// APB register map (byte address = 4 * index)
	localparam int unsigned CFG_REGS   = 8;
	localparam int unsigned PADDR_W    = 5;
	localparam int unsigned PDATA_W    = 32;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VOL_GAIN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLOW_THR  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_DLY = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_TMO  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STP = 3'd7;

	// reset values of the configuration registers
	localparam logic [7:0]  RST_DEBOUNCE  = 8'd2;
	localparam logic [15:0] RST_WINDOW    = 16'd1000;
	localparam logic [23:0] RST_RATE_GAIN = 24'd87381;
	localparam logic [23:0] RST_VOL_GAIN  = 24'd145635;
	localparam logic [15:0] RST_FLOW_THR  = 16'd10;
	localparam logic [15:0] RST_START_DLY = 16'd3000;
	localparam logic [15:0] RST_LINK_TMO  = 16'd3000;
	localparam logic [7:0]  RST_LEVEL_STP = 8'd91;

	typedef struct packed {
		logic        pulse_edge;
		logic        packet_valid;
		logic [7:0]  packet_level;
	} in_item_t;

	typedef struct packed {
		logic        relay_on;
		logic        link_up;
		logic        flow_ok;
		logic        level_full;
		logic [15:0] flow_rate;
		logic [31:0] total_volume;
		logic        window_end;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  debounce_ms;
		logic [15:0] window_ms;
		logic [23:0] rate_gain;
		logic [23:0] volume_gain;
		logic [15:0] flow_threshold;
		logic [15:0] start_delay_ms;
		logic [15:0] link_timeout_ms;
		logic [7:0]  level_stop;
	} cfg_t;

endpackage

`default_nettype wire

// File: design/pfic_cfg.sv
// ----------------------------------------------------------------------------
// pfic_cfg: configuration register file
// APB slave holding the eight control registers; always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module pfic_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pfic_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [pfic_pkg::PDATA_W-1:0]  pwdata,
	output logic      [pfic_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready,
	output pfic_pkg::cfg_t                     cfg
);
	import pfic_pkg::*;

	cfg_t                  cfg_q;
	logic [CFG_IDX_W-1:0]  idx;
	logic                  wr_en;

	assign idx    = paddr[PADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms     <= RST_DEBOUNCE;
			cfg_q.window_ms       <= RST_WINDOW;
			cfg_q.rate_gain       <= RST_RATE_GAIN;
			cfg_q.volume_gain     <= RST_VOL_GAIN;
			cfg_q.flow_threshold  <= RST_FLOW_THR;
			cfg_q.start_delay_ms  <= RST_START_DLY;
			cfg_q.link_timeout_ms <= RST_LINK_TMO;
			cfg_q.level_stop      <= RST_LEVEL_STP;
		end else if (wr_en) begin
			case (idx)
				REG_DEBOUNCE:  cfg_q.debounce_ms     <= pwdata[7:0];
				REG_WINDOW:    cfg_q.window_ms       <= pwdata[15:0];
				REG_RATE_GAIN: cfg_q.rate_gain       <= pwdata[23:0];
				REG_VOL_GAIN:  cfg_q.volume_gain     <= pwdata[23:0];
				REG_FLOW_THR:  cfg_q.flow_threshold  <= pwdata[15:0];
				REG_START_DLY: cfg_q.start_delay_ms  <= pwdata[15:0];
				REG_LINK_TMO:  cfg_q.link_timeout_ms <= pwdata[15:0];
				REG_LEVEL_STP: cfg_q.level_stop      <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			REG_DEBOUNCE:  prdata = {24'd0, cfg_q.debounce_ms};
			REG_WINDOW:    prdata = {16'd0, cfg_q.window_ms};
			REG_RATE_GAIN: prdata = {8'd0, cfg_q.rate_gain};
			REG_VOL_GAIN:  prdata = {8'd0, cfg_q.volume_gain};
			REG_FLOW_THR:  prdata = {16'd0, cfg_q.flow_threshold};
			REG_START_DLY: prdata = {16'd0, cfg_q.start_delay_ms};
			REG_LINK_TMO:  prdata = {16'd0, cfg_q.link_timeout_ms};
			REG_LEVEL_STP: prdata = {24'd0, cfg_q.level_stop};
			default:       prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: design/pfic_core.sv
// ----------------------------------------------------------------------------
// pfic_core: tick state and window-end evaluation
// Holds the debounce, window, volume, link and stability state and computes
// the result word for one tick in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module pfic_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                step,
	input  wire pfic_pkg::in_item_t  item,
	input  wire pfic_pkg::cfg_t      cfg,
	output pfic_pkg::out_item_t      result
);
	import pfic_pkg::*;

	// state registers
	logic [7:0]  since_edge_q;
	logic [15:0] edge_count_q;
	logic [15:0] window_age_q;
	logic [15:0] rate_q;
	logic [47:0] volume_q;
	logic        running_q;
	logic [15:0] stable_age_q;
	logic        stable_flag_q;
	logic        heard_q;
	logic [15:0] packet_age_q;
	logic [7:0]  level_q;
	logic        link_q;
	logic        relay_q;

	// next-state values
	logic [7:0]  since_edge_d;
	logic [15:0] edge_count_d;
	logic [15:0] window_age_d;
	logic [15:0] rate_d;
	logic [47:0] volume_d;
	logic        running_d;
	logic [15:0] stable_age_d;
	logic        stable_flag_d;
	logic        heard_d;
	logic [15:0] packet_age_d;
	logic [7:0]  level_d;
	logic        link_d;
	logic        relay_d;

	logic [7:0]  se_inc;
	logic [15:0] wa_inc;
	logic        counted;
	logic        closing;
	logic        few;
	logic [39:0] rate_prod;
	logic [39:0] vol_prod;
	logic [48:0] vol_sum;
	logic [15:0] rate_new;
	logic [15:0] age_new;

	// per-tick update, then window-end evaluation
	always_comb begin
		se_inc       = (since_edge_q == 8'hFF) ? 8'hFF : since_edge_q + 8'd1;
		packet_age_d = (packet_age_q == 16'hFFFF) ? 16'hFFFF : packet_age_q + 16'd1;
		stable_age_d = stable_age_q;
		if (running_q && stable_age_q != 16'hFFFF)
			stable_age_d = stable_age_q + 16'd1;

		level_d = level_q;
		heard_d = heard_q;
		if (item.packet_valid) begin
			level_d      = item.packet_level;
			heard_d      = 1'b1;
			packet_age_d = '0;
		end

		// debounce: count only edges far enough from the last counted one
		counted      = item.pulse_edge && (se_inc == 8'hFF || se_inc > cfg.debounce_ms);
		since_edge_d = counted ? 8'd0 : se_inc;
		edge_count_d = edge_count_q;
		if (counted && edge_count_q != 16'hFFFF)
			edge_count_d = edge_count_q + 16'd1;

		wa_inc  = (window_age_q == 16'hFFFF) ? 16'hFFFF : window_age_q + 16'd1;
		closing = wa_inc >= cfg.window_ms;
		window_age_d = wa_inc;

		// window-end arithmetic
		few       = edge_count_d < 16'(MIN_PULSES);
		rate_prod = 40'(edge_count_d) * 40'(cfg.rate_gain);
		vol_prod  = 40'(edge_count_d) * 40'(cfg.volume_gain);
		vol_sum   = 49'(volume_q) + 49'(vol_prod);
		if (few)
			rate_new = '0;
		else if (rate_prod[39:32] != 8'd0)
			rate_new = 16'hFFFF;
		else
			rate_new = rate_prod[31:16];

		rate_d        = rate_q;
		volume_d      = volume_q;
		link_d        = link_q;
		running_d     = running_q;
		stable_flag_d = stable_flag_q;
		relay_d       = relay_q;
		age_new       = stable_age_d;

		if (closing) begin
			rate_d = rate_new;
			if (!few)
				volume_d = vol_sum[48] ? {48{1'b1}} : vol_sum[47:0];
			link_d = heard_d && (packet_age_d < cfg.link_timeout_ms);
			// flow stability timer
			if (rate_new > cfg.flow_threshold) begin
				if (!running_q)
					age_new = '0;
				running_d     = 1'b1;
				stable_flag_d = stable_flag_q || (age_new >= cfg.start_delay_ms);
			end else begin
				running_d     = 1'b0;
				age_new       = '0;
				stable_flag_d = 1'b0;
			end
			relay_d      = link_d && (level_d <= cfg.level_stop) && stable_flag_d;
			edge_count_d = '0;
			window_age_d = '0;
		end
		stable_age_d = age_new;

		result.relay_on     = relay_d;
		result.link_up      = link_d;
		result.flow_ok      = stable_flag_d;
		result.level_full   = level_d > cfg.level_stop;
		result.flow_rate    = rate_d;
		result.total_volume = volume_d[47:16];
		result.window_end   = closing;
	end

	// state commit when a word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_edge_q  <= '0;
			edge_count_q  <= '0;
			window_age_q  <= '0;
			rate_q        <= '0;
			volume_q      <= '0;
			running_q     <= 1'b0;
			stable_age_q  <= '0;
			stable_flag_q <= 1'b0;
			heard_q       <= 1'b0;
			packet_age_q  <= '0;
			level_q       <= '0;
			link_q        <= 1'b0;
			relay_q       <= 1'b0;
		end else if (step) begin
			since_edge_q  <= since_edge_d;
			edge_count_q  <= edge_count_d;
			window_age_q  <= window_age_d;
			rate_q        <= rate_d;
			volume_q      <= volume_d;
			running_q     <= running_d;
			stable_age_q  <= stable_age_d;
			stable_flag_q <= stable_flag_d;
			heard_q       <= heard_d;
			packet_age_q  <= packet_age_d;
			level_q       <= level_d;
			link_q        <= link_d;
			relay_q       <= relay_d;
		end
	end

`ifndef SYNTHESIS
	// relay is only driven with a live link and stable flow
	a_relay_needs_link_flow: assert property (@(posedge clk) disable iff (!arst_n)
		relay_q |-> (link_q && stable_flag_q))
		else $error("relay on without link or stable flow");

	// stable flag only while the stability timer runs
	a_flag_needs_running: assert property (@(posedge clk) disable iff (!arst_n)
		stable_flag_q |-> running_q)
		else $error("stable flag set with timer stopped");

	// a stopped timer holds zero age
	a_stopped_age_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> (stable_age_q == 16'd0))
		else $error("stability age nonzero while stopped");

	// a closing tick restarts the window and the pulse count
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && closing) |=> (window_age_q == 16'd0 && edge_count_q == 16'd0))
		else $error("window not cleared after close");

	// total volume never decreases
	a_volume_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (volume_q >= $past(volume_q)))
		else $error("volume total decreased");
`endif

endmodule

`default_nettype wire

// File: design/pump_flow_interlock_controller.sv
// ----------------------------------------------------------------------------
// pump_flow_interlock_controller: pump relay interlock on flow and tank level
// Debounces flow pulses, measures rate and volume per window and decides the
// motor relay from link health, tank level and flow stability.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall / item) carries one word per
//   millisecond tick: flow edge flag plus an optional remote level packet.
//   Output channel (res_valid / res_stall / res) returns exactly one word per
//   input word, in order: relay and status flags, rate, volume, window end.
//   Configuration registers sit on the APB port at byte address 4 * index and
//   should be written only while no word is in flight.
//   Path: an accepted word is held in the input register and its result is
//   computed combinationally and captured in the result register.
//   Throughput: one word per cycle while res_stall is low; the tick state
//   update, including the 16x24 rate and volume products and the 48-bit
//   volume add, is one pass between the input and result registers.
//   Stall: a held result keeps the result register; the input register still
//   takes one more word, after which item_stall rises until res is taken.
//   Reset: arst_n clears all tick state (volume zero, relay off, link down),
//   loads the default register values and empties both pipeline registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pump_flow_interlock_controller (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire pfic_pkg::in_item_t            item,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output pfic_pkg::out_item_t                res,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pfic_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [pfic_pkg::PDATA_W-1:0]  pwdata,
	output logic      [pfic_pkg::PDATA_W-1:0]  prdata,
	output logic                               pready
);
	import pfic_pkg::*;

	cfg_t       cfg;
	in_item_t   item_s1;
	logic       valid_s1;
	out_item_t  result;
	out_item_t  res_q;
	logic       res_valid_q;
	logic       advance;
	logic       take_in;

	pfic_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pfic_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// handshake: input word moves on when the result register is free
	assign advance    = valid_s1 && (!res_valid_q || !res_stall);
	assign item_stall = valid_s1 && !advance;
	assign take_in    = item_valid && !item_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// File: tb/pump_flow_interlock_controller_test.sv
// ----------------------------------------------------------------------------
// pump_flow_interlock_controller_test: self-checking bench for the interlock
// Streams millisecond tick words through the controller with random gaps and
// result stalls, predicts every result word with a cycle-free model of the
// tick update, and compares each returned word with the oldest prediction.
// Configuration is rewritten over APB between phases while nothing is in
// flight; phases cover directed corners, pump start-up runs and noise.
// ----------------------------------------------------------------------------
`default_nettype none

module pump_flow_interlock_controller_test;

	import pfic_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 150;

	// clock, reset and block ports
	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                item_valid = 1'b0;
	logic                item_stall;
	in_item_t            item       = '0;
	logic                res_valid;
	logic                res_stall  = 1'b0;
	out_item_t           res;
	logic                psel       = 1'b0;
	logic                penable    = 1'b0;
	logic                pwrite     = 1'b0;
	logic [PADDR_W-1:0]  paddr      = '0;
	logic [PDATA_W-1:0]  pwdata     = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// stimulus and expected result words
	in_item_t            stim_words[$];
	out_item_t           expected_words[$];

	// bench control
	logic                calm         = 1'b0;
	int unsigned         gap_left     = 0;
	int unsigned         stall_left   = 0;
	int unsigned         hold_left    = 0;
	int unsigned         next_hold_at = 0;
	int unsigned         results_seen = 0;
	int unsigned         mismatches   = 0;
	int unsigned         cycles       = 0;

	// configuration as the block should hold it
	cfg_t cfg_shadow = {RST_DEBOUNCE, RST_WINDOW, RST_RATE_GAIN, RST_VOL_GAIN,
		RST_FLOW_THR, RST_START_DLY, RST_LINK_TMO, RST_LEVEL_STP};

	// tick state of the controller model
	logic [7:0]  edge_gap;
	logic [15:0] pulse_cnt;
	logic [15:0] win_age;
	logic [15:0] rate_q;
	logic [47:0] vol_q16;
	logic        stab_run;
	logic [15:0] stab_age;
	logic        stab_ok;
	logic        link_seen;
	logic [15:0] pkt_age;
	logic [7:0]  level_q;
	logic        link_ok;
	logic        relay_q;

	pump_flow_interlock_controller dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the model by one tick and form the result word
	task automatic step_controller(input in_item_t w, output out_item_t r);
		logic        closing;
		logic [39:0] rate_full;
		logic [39:0] vol_add;
		logic [48:0] vol_sum;
		if (edge_gap != 8'hFF) edge_gap = edge_gap + 8'd1;
		if (pkt_age != 16'hFFFF) pkt_age = pkt_age + 16'd1;
		if (stab_run && stab_age != 16'hFFFF) stab_age = stab_age + 16'd1;

		if (w.packet_valid) begin
			level_q   = w.packet_level;
			link_seen = 1'b1;
			pkt_age   = 16'd0;
		end

		// a saturated gap passes even the widest debounce
		if (w.pulse_edge && (edge_gap == 8'hFF || edge_gap > cfg_shadow.debounce_ms)) begin
			if (pulse_cnt != 16'hFFFF) pulse_cnt = pulse_cnt + 16'd1;
			edge_gap = 8'd0;
		end

		if (win_age != 16'hFFFF) win_age = win_age + 16'd1;
		closing = (win_age >= cfg_shadow.window_ms);

		if (closing) begin
			if (pulse_cnt < MIN_PULSES) begin
				rate_q = 16'd0;
			end else begin
				rate_full = {24'd0, pulse_cnt} * {16'd0, cfg_shadow.rate_gain};
				vol_add   = {24'd0, pulse_cnt} * {16'd0, cfg_shadow.volume_gain};
				rate_q    = (rate_full[39:32] != 8'd0) ? 16'hFFFF : rate_full[31:16];
				vol_sum   = {1'b0, vol_q16} + {9'd0, vol_add};
				vol_q16   = vol_sum[48] ? {48{1'b1}} : vol_sum[47:0];
			end

			link_ok = link_seen && (pkt_age < cfg_shadow.link_timeout_ms);

			// stability timer runs while the rate stays above threshold
			if (rate_q > cfg_shadow.flow_threshold) begin
				if (!stab_run) begin
					stab_run = 1'b1;
					stab_age = 16'd0;
				end
				if (stab_age >= cfg_shadow.start_delay_ms) stab_ok = 1'b1;
			end else begin
				stab_run = 1'b0;
				stab_age = 16'd0;
				stab_ok  = 1'b0;
			end

			relay_q   = link_ok && (level_q <= cfg_shadow.level_stop) && stab_ok;
			pulse_cnt = 16'd0;
			win_age   = 16'd0;
		end

		r.relay_on     = relay_q;
		r.link_up      = link_ok;
		r.flow_ok      = stab_ok;
		r.level_full   = (level_q > cfg_shadow.level_stop);
		r.flow_rate    = rate_q;
		r.total_volume = vol_q16[47:16];
		r.window_end   = closing;
	endtask

	// driver: one word in flight, random gap between words unless calm
	always @(posedge clk or negedge arst_n) begin : driver
		out_item_t pred;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			gap_left   <= 0;
			edge_gap   = 8'd0;
			pulse_cnt  = 16'd0;
			win_age    = 16'd0;
			rate_q     = 16'd0;
			vol_q16    = 48'd0;
			stab_run   = 1'b0;
			stab_age   = 16'd0;
			stab_ok    = 1'b0;
			link_seen  = 1'b0;
			pkt_age    = 16'd0;
			level_q    = 8'd0;
			link_ok    = 1'b0;
			relay_q    = 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				step_controller(item, pred);
				expected_words.push_back(pred);
			end
			if (!item_valid || !item_stall) begin
				if (gap_left != 0) begin
					gap_left   <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (stim_words.size() != 0) begin
					item       <= stim_words.pop_front();
					item_valid <= 1'b1;
					gap_left   <= calm ? 0 : $urandom_range(0, 4);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left    <= 0;
			next_hold_at <= 120;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (results_seen >= next_hold_at) begin
			hold_left    <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + 600;
		end
	end

	// monitor: check each taken result word, draw the next stall
	always @(posedge clk or negedge arst_n) begin : monitor
		out_item_t   want;
		int unsigned wait_n;
		if (!arst_n) begin
			res_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			wait_n = stall_left;
			if (res_valid && !res_stall) begin
				results_seen <= results_seen + 1;
				if (expected_words.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result word at cycle %0d: %h", cycles, res);
					mismatches = mismatches + 1;
				end else begin
					want = expected_words.pop_front();
					if (res !== want) begin
						if (mismatches < 10) begin
							$display("mismatch at cycle %0d:", cycles);
							$display("  exp relay=%0d link=%0d ok=%0d full=%0d rate=%0d vol=%0d wend=%0d",
								want.relay_on, want.link_up, want.flow_ok, want.level_full,
								want.flow_rate, want.total_volume, want.window_end);
							$display("  got relay=%0d link=%0d ok=%0d full=%0d rate=%0d vol=%0d wend=%0d",
								res.relay_on, res.link_up, res.flow_ok, res.level_full,
								res.flow_rate, res.total_volume, res.window_end);
						end
						mismatches = mismatches + 1;
					end
				end
				wait_n = calm ? 0 : $urandom_range(0, 4);
			end
			if (wait_n != 0) begin
				res_stall  <= 1'b1;
				stall_left <= wait_n - 1;
			end else begin
				res_stall  <= (hold_left != 0);
				stall_left <= 0;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// APB write: setup cycle, then access cycle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(input logic [7:0] db, input logic [15:0] win,
		input logic [23:0] rg, input logic [23:0] vg, input logic [15:0] thr,
		input logic [15:0] dly, input logic [15:0] tmo, input logic [7:0] stp);
		write_reg(REG_DEBOUNCE,  {24'd0, db});
		write_reg(REG_WINDOW,    {16'd0, win});
		write_reg(REG_RATE_GAIN, {8'd0, rg});
		write_reg(REG_VOL_GAIN,  {8'd0, vg});
		write_reg(REG_FLOW_THR,  {16'd0, thr});
		write_reg(REG_START_DLY, {16'd0, dly});
		write_reg(REG_LINK_TMO,  {16'd0, tmo});
		write_reg(REG_LEVEL_STP, {24'd0, stp});
		cfg_shadow = {db, win, rg, vg, thr, dly, tmo, stp};
	endtask

	task automatic push_word(input logic pe, input logic pv, input logic [7:0] lvl);
		in_item_t w;
		w.pulse_edge   = pe;
		w.packet_valid = pv;
		w.packet_level = lvl;
		stim_words.push_back(w);
	endtask

	// wait until every word is sent and every result is back
	task automatic wait_idle();
		do @(posedge clk);
		while (stim_words.size() != 0 || item_valid || expected_words.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// random ticks; levels cluster around the given center level, some full range
	task automatic run_random(input int unsigned n, input int unsigned edge_pct,
		input int unsigned pkt_pct, input logic [7:0] center);
		logic [7:0] lvl;
		repeat (n) begin
			case ($urandom_range(0, 5))
				0:       lvl = 8'($urandom);
				1:       lvl = center + 8'($urandom_range(0, 4));
				default: lvl = center - 8'($urandom_range(0, 6));
			endcase
			push_word($urandom_range(0, 99) < edge_pct, $urandom_range(0, 99) < pkt_pct, lvl);
		end
		wait_idle();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings: debounce of two ticks, level right at and above stop
		push_word(1'b1, 1'b0, 8'd0);
		push_word(1'b1, 1'b0, 8'd0);
		push_word(1'b1, 1'b0, 8'd0);
		push_word(1'b1, 1'b0, 8'd0);
		push_word(1'b0, 1'b1, 8'd91);
		push_word(1'b0, 1'b1, 8'd92);
		wait_idle();

		// short window, pulses with no new packet, then level extremes around stop
		configure(8'd0, 16'd4, 24'hFFFFFF, 24'hFFFFFF, 16'd0, 16'd0, 16'd3, 8'd100);
		push_word(1'b1, 1'b0, 8'd255);
		push_word(1'b1, 1'b0, 8'd0);
		push_word(1'b1, 1'b0, 8'd255);
		push_word(1'b1, 1'b0, 8'd0);
		push_word(1'b1, 1'b1, 8'd0);
		push_word(1'b1, 1'b1, 8'd255);
		push_word(1'b1, 1'b1, 8'd100);
		push_word(1'b1, 1'b1, 8'd101);
		push_word(1'b1, 1'b1, 8'd100);
		push_word(1'b0, 1'b0, 8'd0);
		push_word(1'b1, 1'b0, 8'd255);
		push_word(1'b1, 1'b0, 8'd0);
		push_word(1'b0, 1'b1, 8'd100);
		push_word(1'b1, 1'b0, 8'd0);
		push_word(1'b1, 1'b0, 8'd0);
		push_word(1'b0, 1'b0, 8'd0);
		wait_idle();

		// pump start-up runs: steady pulses, regular level packets
		configure(8'd0, 16'd8, 24'h080000, 24'($urandom), 16'd12, 16'd24, 16'd40, 8'd90);
		run_random(250, 70, 15, 8'd90);

		// zero window: every tick closes one
		calm = 1'b1;
		configure(8'd1, 16'd0, 24'hFFFFFF, 24'h010000, 16'd0, 16'd0, 16'd5, 8'd128);
		run_random(60, 50, 30, 8'd128);

		// pulse on every tick for a long window: rate saturates
		configure(8'd0, 16'd260, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFE, 16'd0, 16'hFFFF, 8'd255);
		run_random(280, 100, 5, 8'd200);

		// widest debounce: only a saturated edge gap lets pulses through
		calm = 1'b0;
		configure(8'd255, 16'd520, 24'h7FFFFF, 24'hFFFFFF, 16'd5, 16'd0, 16'd600, 8'd50);
		run_random(530, 60, 2, 8'd50);

		// zero link timeout, zero gains, one-tick window, top flow and start thresholds, zero stop level
		configure(8'd3, 16'd1, 24'd0, 24'd0, 16'hFFFF, 16'hFFFF, 16'd0, 8'd0);
		run_random(100, 50, 50, 8'd0);

		// longest window
		configure(8'd7, 16'hFFFF, 24'($urandom), 24'($urandom), 16'($urandom),
			16'($urandom), 16'hFFFF, 8'($urandom));
		run_random(30, 50, 50, 8'($urandom));

		// randomized pump runs
		configure(8'($urandom_range(0, 3)), 16'($urandom_range(6, 16)),
			24'($urandom_range(24'h020000, 24'h200000)), 24'($urandom),
			16'($urandom_range(0, 20)), 16'($urandom_range(0, 40)),
			16'($urandom_range(20, 80)), 8'($urandom_range(40, 220)));
		run_random(120, 60, 20, cfg_shadow.level_stop);

		if (expected_words.size() != 0) mismatches = mismatches + 1;
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
